### rtl/core/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset (active low) is asserted.
`define ASSERT_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mwsm_pkg.sv
// Shared types, widths and constants of the mecanum wheel speed mixer.
package mwsm_pkg;

    localparam int STICK_W  = 16;
    localparam int DPAD_W   = 2;
    localparam int TERM_W   = 20;   // mixed wheel term, Q16, signed
    localparam int MAG_W    = 19;   // term magnitude and quotient
    localparam int CMD_W    = 13;
    localparam int SCALE_W  = 10;
    localparam int FRAC_W   = 32;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int P_W      = SQ_W + SCALE_W;
    localparam int INT_W    = P_W - FRAC_W;
    localparam int NWHEEL   = 4;
    localparam int IDX_W    = $clog2(NWHEEL);
    localparam int DIV_STEPS = MAG_W;
    localparam int DCNT_W   = $clog2(DIV_STEPS);

    localparam int TDATA_IN_W  = 40;
    localparam int TDATA_OUT_W = 56;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam int Q16_0707 = 46334;
    localparam int Q16_ONE  = 65536;

    localparam logic [SCALE_W-1:0] SCALE_RESET    = SCALE_W'(350);
    localparam logic [SCALE_W-1:0] DEADBAND_RESET = SCALE_W'(30);

    localparam logic signed [CMD_W-1:0] CMD_MAX = CMD_W'(4095);
    localparam logic signed [CMD_W-1:0] CMD_MIN = CMD_W'(-4096);

    localparam logic REG_WHEEL_SCALE = 1'b0;
    localparam logic REG_DEADBAND    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             clr;
        logic             mix;
        logic             div_init;
        logic             div_step;
        logic             mul_sq;
        logic             mul_sc;
        logic             fin;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic stop;
        logic out_free;
    } dp_stat_t;

    // d-pad direction times 0.707 in Q16; pattern 10 counts as -2
    function automatic logic signed [TERM_W-1:0] dpad_term(input logic [DPAD_W-1:0] d);
        logic signed [TERM_W-1:0] one;
        one = TERM_W'(Q16_0707);
        case (d)
            2'b01:   dpad_term = one;
            2'b11:   dpad_term = -one;
            2'b10:   dpad_term = -(one <<< 1);
            default: dpad_term = '0;
        endcase
    endfunction

endpackage

### rtl/core/mwsm_regs.sv
// APB register file: wheel scale and deadband.
module mwsm_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwsm_pkg::APB_AW-1:0]         paddr,
    input  logic [mwsm_pkg::APB_DW-1:0]         pwdata,
    output logic [mwsm_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    output logic [mwsm_pkg::SCALE_W-1:0]        wheel_scale,
    output logic [mwsm_pkg::SCALE_W-1:0]        deadband
);

    logic [mwsm_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic [mwsm_pkg::SCALE_W-1:0] db_reg, db_next;
    logic                         wr_en;
    logic                         sel;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    // one register per word; low address bits are ignored
    assign sel    = paddr[2];

    always_comb begin
        scale_next = scale_reg;
        db_next    = db_reg;
        if (wr_en) begin
            case (sel)
                mwsm_pkg::REG_WHEEL_SCALE: scale_next = pwdata[mwsm_pkg::SCALE_W-1:0];
                mwsm_pkg::REG_DEADBAND:    db_next    = pwdata[mwsm_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= mwsm_pkg::SCALE_RESET;
            db_reg    <= mwsm_pkg::DEADBAND_RESET;
        end else begin
            scale_reg <= scale_next;
            db_reg    <= db_next;
        end
    end

    always_comb begin
        case (sel)
            mwsm_pkg::REG_WHEEL_SCALE: prdata = mwsm_pkg::APB_DW'(scale_reg);
            mwsm_pkg::REG_DEADBAND:    prdata = mwsm_pkg::APB_DW'(db_reg);
            default:                   prdata = '0;
        endcase
    end

    assign wheel_scale = scale_reg;
    assign deadband    = db_reg;

endmodule

### rtl/core/mwsm_ctrl.sv
// Sequencer: mix (or clear for a stop item), max, 19-step divide, shared multiply per wheel, output load.
module mwsm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mwsm_pkg::dp_stat_t   stat,
    output mwsm_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX  = 3'd1;
    localparam logic [2:0] ST_MAXD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_SC   = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    localparam logic [mwsm_pkg::DCNT_W-1:0] DCNT_LAST = mwsm_pkg::DCNT_W'(mwsm_pkg::DIV_STEPS - 1);
    localparam logic [mwsm_pkg::IDX_W-1:0]  IDX_LAST  = mwsm_pkg::IDX_W'(mwsm_pkg::NWHEEL - 1);

    logic [2:0]                      state_reg, state_next;
    logic [mwsm_pkg::DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic [mwsm_pkg::IDX_W-1:0]      idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // closed while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                if (stat.stop) begin
                    cmd.clr    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.mix    = 1'b1;
                    state_next = ST_MAXD;
                end
            end
            ST_MAXD: begin
                cmd.div_init = 1'b1;
                dcnt_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                dcnt_next    = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_LAST) begin
                    idx_next   = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.mul_sq = 1'b1;
                state_next = ST_SC;
            end
            ST_SC: begin
                cmd.mul_sc = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                if (idx_reg == IDX_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dcnt_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

### rtl/core/mwsm_dpath.sv
// Datapath: input capture, wheel mixing, max, four divider lanes, multipliers, output register.
module mwsm_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mwsm_pkg::dp_cmd_t                    cmd,
    output mwsm_pkg::dp_stat_t                   stat,
    input  logic [mwsm_pkg::TDATA_IN_W-1:0]      s_tdata,
    input  logic                                 s_tuser,
    input  logic [mwsm_pkg::SCALE_W-1:0]         wheel_scale,
    input  logic [mwsm_pkg::SCALE_W-1:0]         deadband,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mwsm_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic [mwsm_pkg::NWHEEL-1:0]          m_tuser
);

    localparam int TW = mwsm_pkg::TERM_W;
    localparam int MW = mwsm_pkg::MAG_W;
    localparam int CW = mwsm_pkg::CMD_W;
    localparam int NW = mwsm_pkg::NWHEEL;
    localparam int PAD_W = mwsm_pkg::TDATA_OUT_W - NW * CW;
    localparam logic [mwsm_pkg::INT_W-1:0] C_MIN_MAG = mwsm_pkg::INT_W'(4096);
    localparam logic [mwsm_pkg::INT_W-1:0] C_MAX_MAG = mwsm_pkg::INT_W'(4095);

    // captured input word
    logic                                  act_reg;
    logic signed [mwsm_pkg::STICK_W-1:0]   sx_reg, sy_reg;
    logic [mwsm_pkg::DPAD_W-1:0]           dx_reg, dy_reg;

    logic signed [TW-1:0]  term_reg [NW];
    logic [MW-1:0]         m_reg;
    logic [MW-1:0]         rem_reg [NW];
    logic [MW-1:0]         sh_reg  [NW];
    logic [mwsm_pkg::SQ_W-1:0] sq_reg;
    logic [mwsm_pkg::P_W-1:0]  p_reg;
    logic signed [CW-1:0]  cmd_reg  [NW];
    logic signed [CW-1:0]  last_reg [NW];

    logic                               m_tvalid_reg;
    logic [mwsm_pkg::TDATA_OUT_W-1:0]   m_tdata_reg;
    logic [NW-1:0]                      m_tuser_reg;

    logic signed [TW-1:0]  jx, jy, dxv, dyv;
    logic signed [TW-1:0]  mix_val [NW];
    logic signed [TW-1:0]  max_val;
    logic [MW-1:0]         mag [NW];
    logic [MW:0]           trial [NW];
    logic                  ge [NW];

    logic [mwsm_pkg::INT_W-1:0] c_int;
    logic                       above_db;
    logic                       eneg;
    logic signed [CW-1:0]       fin_val;

    // mixing
    assign jx  = TW'(sx_reg);
    assign jy  = TW'(sy_reg) <<< 1;
    assign dxv = mwsm_pkg::dpad_term(dx_reg);
    assign dyv = mwsm_pkg::dpad_term(dy_reg);

    assign mix_val[0] = jy + jx + dxv + dyv;   // front left
    assign mix_val[1] = jy - jx - dxv + dyv;   // front right
    assign mix_val[2] = jy + jx - dxv + dyv;   // rear left
    assign mix_val[3] = jy - jx + dxv + dyv;   // rear right

    // signed max with 1.0 floor, so the result is positive
    always_comb begin
        max_val = TW'(mwsm_pkg::Q16_ONE);
        for (int i = 0; i < NW; i++) begin
            if (term_reg[i] > max_val) max_val = term_reg[i];
        end
    end

    // restoring divide lanes: quotient = (mag << 16) / m, one bit per step
    always_comb begin
        for (int i = 0; i < NW; i++) begin
            mag[i]   = term_reg[i][TW-1] ? MW'(-term_reg[i]) : MW'(term_reg[i]);
            trial[i] = {rem_reg[i], sh_reg[i][MW-1]};
            ge[i]    = trial[i] >= {1'b0, m_reg};
        end
    end

    // final scaling: deadband, truncate, sign, mounting negation, saturate
    always_comb begin
        c_int    = p_reg[mwsm_pkg::P_W-1:mwsm_pkg::FRAC_W];
        above_db = p_reg > {mwsm_pkg::INT_W'(deadband), mwsm_pkg::FRAC_W'(0)};
        eneg     = term_reg[cmd.idx][TW-1] ^ cmd.idx[0];
        if (!above_db) begin
            fin_val = '0;
        end else if (eneg) begin
            fin_val = (c_int >= C_MIN_MAG) ? mwsm_pkg::CMD_MIN : -$signed(c_int[CW-1:0]);
        end else begin
            fin_val = (c_int >= C_MAX_MAG) ? mwsm_pkg::CMD_MAX : $signed(c_int[CW-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= s_tuser;
            sx_reg  <= s_tdata[15:0];
            sy_reg  <= s_tdata[31:16];
            dx_reg  <= s_tdata[33:32];
            dy_reg  <= s_tdata[35:34];
        end
        if (cmd.mix) begin
            for (int i = 0; i < NW; i++) term_reg[i] <= mix_val[i];
        end
        if (cmd.div_init) begin
            m_reg <= max_val[MW-1:0];
            for (int i = 0; i < NW; i++) begin
                rem_reg[i] <= MW'(mag[i][MW-1:3]);
                sh_reg[i]  <= {mag[i][2:0], 16'b0};
            end
        end
        if (cmd.div_step) begin
            for (int i = 0; i < NW; i++) begin
                rem_reg[i] <= ge[i] ? MW'(trial[i] - {1'b0, m_reg}) : trial[i][MW-1:0];
                sh_reg[i]  <= {sh_reg[i][MW-2:0], ge[i]};
            end
        end
        if (cmd.mul_sq) sq_reg <= sh_reg[cmd.idx] * sh_reg[cmd.idx];
        if (cmd.mul_sc) p_reg  <= sq_reg * wheel_scale;
        if (cmd.clr) begin
            for (int i = 0; i < NW; i++) cmd_reg[i] <= '0;
        end
        if (cmd.fin) cmd_reg[cmd.idx] <= fin_val;
        if (cmd.out_load) begin
            m_tdata_reg <= {PAD_W'(0), cmd_reg[3], cmd_reg[2], cmd_reg[1], cmd_reg[0]};
            for (int i = 0; i < NW; i++) m_tuser_reg[i] <= cmd_reg[i] != last_reg[i];
        end
    end

    // last-sent commands and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < NW; i++) last_reg[i] <= '0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
                for (int i = 0; i < NW; i++) last_reg[i] <= cmd_reg[i];
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.stop     = act_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/core/mecanum_wheel_speed_mixer.sv
// A drive item is captured, mixed and maxed, then run through the 19-step divider
// (one quotient bit per cycle); each of the four wheels then takes a square, a scale
// multiply and a final step in turn. A stop item clears the commands instead.
// The result is loaded once the output register is free; s_tready is high only when idle.
// A finished word waits in the output register while the next item is accepted.
// Reset (aresetn low, synchronous) clears the sequencer, m_tvalid and last-sent commands.
module mecanum_wheel_speed_mixer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // stick_x[15:0], stick_y[31:16], dpad_x[33:32], dpad_y[35:34], zero fill
    input  logic [mwsm_pkg::TDATA_IN_W-1:0]      s_tdata,
    // action
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // front_left_cmd[12:0], front_right_cmd[25:13], rear_left_cmd[38:26],
    // rear_right_cmd[51:39], zero fill
    output logic [mwsm_pkg::TDATA_OUT_W-1:0]     m_tdata,
    // front_left_new, front_right_new, rear_left_new, rear_right_new
    output logic [mwsm_pkg::NWHEEL-1:0]          m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mwsm_pkg::APB_AW-1:0]          paddr,
    input  logic [mwsm_pkg::APB_DW-1:0]          pwdata,
    output logic [mwsm_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);

    mwsm_pkg::dp_cmd_t            cmd;
    mwsm_pkg::dp_stat_t           stat;
    logic [mwsm_pkg::SCALE_W-1:0] wheel_scale;
    logic [mwsm_pkg::SCALE_W-1:0] deadband;

    mwsm_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .wheel_scale (wheel_scale),
        .deadband    (deadband)
    );

    mwsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mwsm_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .wheel_scale (wheel_scale),
        .deadband    (deadband),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### rtl/core/mwsm_checker.sv
// Port-level checks for the mecanum wheel speed mixer, bound to the top level.
`include "assert_macros.svh"

module mwsm_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [mwsm_pkg::TDATA_OUT_W-1:0]     m_tdata,
    input logic [mwsm_pkg::NWHEEL-1:0]          m_tuser,
    input logic                                 pready
);

    // one item in flight: the input side closes right after an accept
    `ASSERT_SYNC(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "input ready stayed high after accept")

    // no result can appear in the cycle right after an accept
    `ASSERT_SYNC(a_no_instant_result, aclk, aresetn, s_tvalid && s_tready |=> !$rose(m_tvalid), "result appeared too early")

    // loading a result returns the sequencer to idle
    `ASSERT_SYNC(a_idle_on_result, aclk, aresetn, $rose(m_tvalid) |-> s_tready, "not ready for input when result loaded")

    // a stalled result word holds
    `ASSERT_SYNC(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output changed")

    `ASSERT_ALWAYS(a_pready_high, aclk, pready, "pready dropped")

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_mwsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
